// File: rtl/irs_pkg.sv
package irs_pkg;

  // Data memory depth in words. It must be a power of two so that address
  // wrapping is a plain truncation.
  localparam int MEM_WORDS = 4096;
  localparam int MEM_AW = $clog2(MEM_WORDS);

  localparam int XLEN = 32;
  localparam int NREGS = 32;
  localparam int REG_AW = 5;
  localparam int MEM_ADDR_W = 12;

  localparam logic [XLEN-1:0] JUMP_REGION_MASK = 32'hF000_0000;

  // Primary opcodes.
  localparam logic [5:0] OP_RTYPE = 6'd0;
  localparam logic [5:0] OP_J = 6'd2;
  localparam logic [5:0] OP_JAL = 6'd3;
  localparam logic [5:0] OP_BEQ = 6'd4;
  localparam logic [5:0] OP_BNE = 6'd5;
  localparam logic [5:0] OP_ADDI = 6'd8;
  localparam logic [5:0] OP_SLTI = 6'd10;
  localparam logic [5:0] OP_ORI = 6'd13;
  localparam logic [5:0] OP_LUI = 6'd15;
  localparam logic [5:0] OP_COP1 = 6'd17;
  localparam logic [5:0] OP_LW = 6'd35;
  localparam logic [5:0] OP_SW = 6'd43;
  localparam logic [5:0] OP_LWC1 = 6'd49;
  localparam logic [5:0] OP_SWC1 = 6'd57;
  localparam logic [5:0] OP_IO_A = 6'd60;
  localparam logic [5:0] OP_IO_B = 6'd61;
  localparam logic [5:0] OP_IO_C = 6'd62;
  localparam logic [5:0] OP_IO_D = 6'd63;

  // Function codes of the register-register group.
  localparam logic [5:0] FN_SLL = 6'd0;
  localparam logic [5:0] FN_SRL = 6'd2;
  localparam logic [5:0] FN_JR = 6'd8;
  localparam logic [5:0] FN_ADD = 6'd32;
  localparam logic [5:0] FN_SUB = 6'd34;
  localparam logic [5:0] FN_SLT = 6'd42;

  typedef enum logic [1:0] {
    ST_OK = 2'd0,
    ST_BAD_FUNCT = 2'd1,
    ST_UNSUPPORTED = 2'd2,
    ST_INVALID = 2'd3
  } status_t;

  // Everything the execute logic decides for one instruction.
  typedef struct packed {
    logic [XLEN-1:0] npc;
    logic we;
    logic [REG_AW-1:0] widx;
    logic [XLEN-1:0] wval;
    logic mwe;
    logic [MEM_AW-1:0] maddr;
    logic [XLEN-1:0] mval;
    status_t status;
    logic is_load;
  } ex_res_t;

endpackage

// File: rtl/irs_regfile.sv
module irs_regfile (
  input  logic clk,
  input  logic rst,
  input  logic rd_en,
  input  logic [irs_pkg::REG_AW-1:0] rs_idx,
  input  logic [irs_pkg::REG_AW-1:0] rt_idx,
  input  logic wr_en,
  input  logic [irs_pkg::REG_AW-1:0] wr_idx,
  input  logic [irs_pkg::XLEN-1:0] wr_data,
  output logic [irs_pkg::XLEN-1:0] rs_data,
  output logic [irs_pkg::XLEN-1:0] rt_data
);
  import irs_pkg::*;

  logic [XLEN-1:0] mem [NREGS];
  logic [NREGS-1:0] vld;
  logic [XLEN-1:0] rs_q;
  logic [XLEN-1:0] rt_q;
  logic [XLEN-1:0] byp_q;
  logic rs_byp;
  logic rt_byp;
  logic rs_zero;
  logic rt_zero;

  // An entry that was never written since reset reads as zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (wr_en) begin
      vld[wr_idx] <= 1'b1;
    end
  end

  // A write in the same cycle as the read is forwarded to the reader.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
    if (rd_en) begin
      rs_q <= mem[rs_idx];
      rt_q <= mem[rt_idx];
      byp_q <= wr_data;
      rs_byp <= wr_en && (wr_idx == rs_idx);
      rt_byp <= wr_en && (wr_idx == rt_idx);
      rs_zero <= (rs_idx == '0) || !vld[rs_idx];
      rt_zero <= (rt_idx == '0) || !vld[rt_idx];
    end
  end

  assign rs_data = rs_byp ? byp_q : (rs_zero ? '0 : rs_q);
  assign rt_data = rt_byp ? byp_q : (rt_zero ? '0 : rt_q);

endmodule

// File: rtl/irs_exec.sv
module irs_exec (
  input  logic [irs_pkg::XLEN-1:0] instr,
  input  logic [irs_pkg::XLEN-1:0] pc,
  input  logic [irs_pkg::XLEN-1:0] a,
  input  logic [irs_pkg::XLEN-1:0] b,
  output irs_pkg::ex_res_t res
);
  import irs_pkg::*;

  logic [5:0] op;
  logic [5:0] fn;
  logic [REG_AW-1:0] rt;
  logic [REG_AW-1:0] rd;
  logic [4:0] sh;
  logic [15:0] imm;
  logic [XLEN-1:0] simm;
  logic [XLEN-1:0] pc4;
  logic [XLEN-1:0] br_target;
  logic [XLEN-1:0] jmp_target;
  logic [XLEN-1:0] ea;
  logic lt_ab;
  logic lt_ai;

  assign op = instr[31:26];
  assign rt = instr[20:16];
  assign rd = instr[15:11];
  assign sh = instr[10:6];
  assign fn = instr[5:0];
  assign imm = instr[15:0];
  assign simm = {{16{imm[15]}}, imm};
  assign pc4 = pc + 32'd4;
  assign br_target = pc4 + {simm[XLEN-3:0], 2'b00};
  assign jmp_target = (pc4 & JUMP_REGION_MASK) | {4'b0000, instr[25:0], 2'b00};
  assign ea = a + simm;
  assign lt_ab = $signed(a) < $signed(b);
  assign lt_ai = $signed(a) < $signed(simm);

  always_comb begin
    res = '0;
    res.npc = pc4;
    res.status = ST_OK;
    case (op)
      OP_RTYPE: begin
        case (fn)
          FN_ADD: begin
            res.we = 1'b1; res.widx = rd; res.wval = a + b;
          end
          FN_SUB: begin
            res.we = 1'b1; res.widx = rd; res.wval = a - b;
          end
          FN_JR: begin
            res.npc = a;
          end
          FN_SLT: begin
            res.we = 1'b1; res.widx = rd; res.wval = {31'd0, lt_ab};
          end
          FN_SLL: begin
            res.we = 1'b1; res.widx = rd; res.wval = b << sh;
          end
          FN_SRL: begin
            // A logical right shift by zero leaves the destination alone.
            res.we = (sh != 5'd0); res.widx = rd; res.wval = b >> sh;
          end
          default: begin
            res.status = ST_BAD_FUNCT;
          end
        endcase
      end
      OP_J: begin
        res.npc = jmp_target;
      end
      OP_JAL: begin
        res.we = 1'b1; res.widx = 5'd31; res.wval = pc4;
        res.npc = jmp_target;
      end
      OP_BEQ: begin
        if (a == b) res.npc = br_target;
      end
      OP_BNE: begin
        if (a != b) res.npc = br_target;
      end
      OP_ADDI: begin
        res.we = 1'b1; res.widx = rt; res.wval = ea;
      end
      OP_SLTI: begin
        res.we = 1'b1; res.widx = rt; res.wval = {31'd0, lt_ai};
      end
      OP_ORI: begin
        res.we = 1'b1; res.widx = rt; res.wval = a | {16'd0, imm};
      end
      OP_LUI: begin
        res.we = 1'b1; res.widx = rt; res.wval = {imm, 16'd0};
      end
      OP_LW: begin
        // The loaded word arrives from the data memory in the following cycle.
        res.we = 1'b1; res.widx = rt; res.is_load = 1'b1;
        res.maddr = ea[MEM_AW-1:0];
      end
      OP_SW: begin
        res.mwe = 1'b1; res.mval = b;
        res.maddr = ea[MEM_AW-1:0];
      end
      OP_COP1, OP_LWC1, OP_SWC1, OP_IO_A, OP_IO_B, OP_IO_C, OP_IO_D: begin
        res.status = ST_UNSUPPORTED;
      end
      default: begin
        res.status = ST_INVALID;
        res.npc = pc;
      end
    endcase

    // Writes to register zero are dropped and reported as no write.
    if (res.widx == '0) res.we = 1'b0;
    if (!res.we) begin
      res.widx = '0;
      res.wval = '0;
    end
  end

endmodule

// File: rtl/irs_dmem.sv
module irs_dmem (
  input  logic clk,
  input  logic rst,
  input  logic wr_en,
  input  logic rd_en,
  input  logic [irs_pkg::MEM_AW-1:0] addr,
  input  logic [irs_pkg::XLEN-1:0] wr_data,
  output logic [irs_pkg::XLEN-1:0] rd_data,
  output logic busy
);
  import irs_pkg::*;

  logic [XLEN-1:0] mem [MEM_WORDS];
  logic [MEM_AW-1:0] sweep_addr;

  // After reset every word is written with zero, one word per cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
      sweep_addr <= '0;
    end else if (busy) begin
      sweep_addr <= sweep_addr + 1'b1;
      if (sweep_addr == MEM_AW'(MEM_WORDS - 1)) busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      mem[sweep_addr] <= '0;
    end else if (wr_en) begin
      mem[addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[addr];
    end
  end

endmodule

// File: rtl/integer_risc_instruction_step.sv
// Executes one 32-bit integer instruction per request on a small core with a
// 32-entry register file, a byte program counter and a word data memory.
//
// Request channel: instr with instr_valid; the block raises instr_stall when it
// cannot take a request. Result channel: next_pc, register write, store and
// status with result_valid; the receiver raises result_stall to hold a result.
//
// An accepted instruction is decoded and executed in the cycle after it is
// taken; its result is registered in the output register once that is free.
// A load waits in the load write-back stage for its data memory read. Non-load
// instructions are accepted in every cycle while the result side is not
// stalled; a load blocks the request channel while it is in the execute stage,
// since the next instruction may read the loaded register.
//
// Reset clears the registers and the program counter at once, then the data
// memory is swept to zero, one word per cycle, over all MEM_WORDS words;
// instr_stall stays high until the sweep has finished.
//
// A stalled result holds in the output register. One more instruction may wait
// behind it (a load moves on to write-back); then the request channel stalls.
module integer_risc_instruction_step (
  input  logic clk,
  input  logic rst,
  input  logic [31:0] instr,
  input  logic instr_valid,
  output logic instr_stall,
  output logic [31:0] next_pc,
  output logic reg_we,
  output logic [4:0] reg_idx,
  output logic [31:0] reg_val,
  output logic mem_we,
  output logic [11:0] mem_addr,
  output logic [31:0] mem_val,
  output logic [1:0] status,
  output logic result_valid,
  input  logic result_stall
);
  import irs_pkg::*;

  // Execute stage.
  logic s1_valid;
  logic [XLEN-1:0] s1_instr;
  logic [XLEN-1:0] pc_reg;
  logic [XLEN-1:0] rs_data;
  logic [XLEN-1:0] rt_data;
  ex_res_t ex;

  // Load write-back stage.
  logic s2_valid;
  logic s2_we;
  logic [REG_AW-1:0] s2_idx;
  logic [MEM_AW-1:0] s2_maddr;
  logic [XLEN-1:0] ld_data;

  logic clearing;
  logic accept;
  logic out_free;
  logic s1_fire;
  logic s2_fire;
  logic rf_wr_en;
  logic [REG_AW-1:0] rf_wr_idx;
  logic [XLEN-1:0] rf_wr_data;

  // The output register can take a new result when it is empty or being read.
  assign out_free = !result_valid || !result_stall;

  // A load always moves on to the write-back stage; anything else needs room
  // in the output register.
  assign s1_fire = s1_valid && (ex.is_load || out_free);
  assign s2_fire = s2_valid && out_free;

  // Requests wait during the memory sweep, behind a load, and whenever the
  // stage ahead cannot empty in this cycle.
  assign instr_stall = clearing
                    || (s1_valid && (ex.is_load || !out_free))
                    || (s2_valid && !out_free);
  assign accept = instr_valid && !instr_stall;

  // Only one stage holds an instruction at a time when a load is in flight,
  // so the two register write sources never collide.
  assign rf_wr_en = (s2_fire && s2_we) || (s1_fire && !ex.is_load && ex.we);
  assign rf_wr_idx = s2_valid ? s2_idx : ex.widx;
  assign rf_wr_data = s2_valid ? ld_data : ex.wval;

  irs_regfile u_regfile (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (accept),
    .rs_idx  (instr[25:21]),
    .rt_idx  (instr[20:16]),
    .wr_en   (rf_wr_en),
    .wr_idx  (rf_wr_idx),
    .wr_data (rf_wr_data),
    .rs_data (rs_data),
    .rt_data (rt_data)
  );

  irs_exec u_exec (
    .instr (s1_instr),
    .pc    (pc_reg),
    .a     (rs_data),
    .b     (rt_data),
    .res   (ex)
  );

  irs_dmem u_dmem (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (s1_fire && ex.mwe),
    .rd_en   (s1_fire && ex.is_load),
    .addr    (ex.maddr),
    .wr_data (ex.mval),
    .rd_data (ld_data),
    .busy    (clearing)
  );

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      result_valid <= 1'b0;
      pc_reg <= '0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (s1_fire) begin
        s1_valid <= 1'b0;
      end

      if (s1_fire) begin
        pc_reg <= ex.npc;
      end

      if (s1_fire && ex.is_load) begin
        s2_valid <= 1'b1;
      end else if (s2_fire) begin
        s2_valid <= 1'b0;
      end

      if ((s1_fire && !ex.is_load) || s2_fire) begin
        result_valid <= 1'b1;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_instr <= instr;
    end

    if (s1_fire && ex.is_load) begin
      s2_we <= ex.we;
      s2_idx <= ex.widx;
      s2_maddr <= ex.maddr;
    end

    if (s2_fire) begin
      // The program counter already holds the load's successor.
      next_pc <= pc_reg;
      reg_we <= s2_we;
      reg_idx <= s2_idx;
      reg_val <= s2_we ? ld_data : '0;
      mem_we <= 1'b0;
      mem_addr <= MEM_ADDR_W'(s2_maddr);
      mem_val <= '0;
      status <= ST_OK;
    end else if (s1_fire && !ex.is_load) begin
      next_pc <= ex.npc;
      reg_we <= ex.we;
      reg_idx <= ex.widx;
      reg_val <= ex.wval;
      mem_we <= ex.mwe;
      mem_addr <= MEM_ADDR_W'(ex.maddr);
      mem_val <= ex.mval;
      status <= ex.status;
    end
  end

endmodule

// File: rtl/irs_checker.sv
module irs_checker (
  input logic clk,
  input logic rst,
  input logic instr_stall,
  input logic [31:0] next_pc,
  input logic reg_we,
  input logic [4:0] reg_idx,
  input logic [31:0] reg_val,
  input logic mem_we,
  input logic [11:0] mem_addr,
  input logic [31:0] mem_val,
  input logic [1:0] status,
  input logic result_valid,
  input logic result_stall
);
  import irs_pkg::*;

  // A held result keeps its valid and its payload.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(next_pc)
      && $stable(reg_we) && $stable(reg_idx) && $stable(reg_val)
      && $stable(mem_we) && $stable(mem_addr) && $stable(mem_val) && $stable(status))
    else $error("stalled result changed");

  // No register write means index and value are reported as zero.
  a_no_write: assert property (@(posedge clk) disable iff (rst)
    result_valid && !reg_we |-> reg_idx == 5'd0 && reg_val == 32'd0)
    else $error("register fields set without a write");

  // A store writes no register and always completes normally.
  a_store: assert property (@(posedge clk) disable iff (rst)
    result_valid && mem_we |-> !reg_we && status == ST_OK)
    else $error("store reported a register write or bad status");

  // Faulting instructions write nothing.
  a_fault: assert property (@(posedge clk) disable iff (rst)
    result_valid && (status == ST_BAD_FUNCT || status == ST_UNSUPPORTED
      || status == ST_INVALID) |-> !reg_we && !mem_we)
    else $error("faulting instruction wrote state");

  // Right after reset there is no result and requests wait for the sweep.
  a_reset: assert property (@(posedge clk)
    rst |=> !result_valid && instr_stall)
    else $error("block not quiet after reset");

endmodule

bind integer_risc_instruction_step irs_checker u_irs_checker (.*);

// File: sim/tb_integer_risc_instruction_step.sv
module tb_integer_risc_instruction_step;
  timeunit 1ns;
  timeprecision 1ps;

  import irs_pkg::*;

  // Number of random requests that follow the directed drill.
  localparam int RANDOM_ITEMS = 975;
  // Length of the long result hold-off that makes the block back up.
  localparam int HOLD_CYCLES = 300;
  // Cycles to keep watching the result port once nothing is outstanding.
  localparam int DRAIN_CYCLES = 20;

  // One retired instruction as it appears on the result port.
  typedef struct packed {
    logic [XLEN-1:0] npc;
    logic we;
    logic [REG_AW-1:0] idx;
    logic [XLEN-1:0] val;
    logic mwe;
    logic [MEM_ADDR_W-1:0] maddr;
    logic [XLEN-1:0] mval;
    status_t st;
  } retire_t;

  // One line of the directed drill. When known is set, want holds the result
  // written out by hand; otherwise the architectural model supplies it.
  typedef struct packed {
    logic [31:0] w;
    logic known;
    retire_t want;
  } drill_row_t;

  logic clk = 1'b0;
  logic rst;
  logic [31:0] instr;
  logic instr_valid;
  logic instr_stall;
  logic [31:0] next_pc;
  logic reg_we;
  logic [4:0] reg_idx;
  logic [31:0] reg_val;
  logic mem_we;
  logic [11:0] mem_addr;
  logic [31:0] mem_val;
  logic [1:0] status;
  logic result_valid;
  logic result_stall;

  integer_risc_instruction_step u_dut (
    .clk(clk),
    .rst(rst),
    .instr(instr),
    .instr_valid(instr_valid),
    .instr_stall(instr_stall),
    .next_pc(next_pc),
    .reg_we(reg_we),
    .reg_idx(reg_idx),
    .reg_val(reg_val),
    .mem_we(mem_we),
    .mem_addr(mem_addr),
    .mem_val(mem_val),
    .status(status),
    .result_valid(result_valid),
    .result_stall(result_stall)
  );

  always #5 clk = ~clk;

  // Architectural state of the core as the testbench believes it to be. It
  // advances once per accepted request, in acceptance order.
  logic [XLEN-1:0] arch_gpr [NREGS];
  logic [XLEN-1:0] arch_pc;
  logic [XLEN-1:0] arch_mem [MEM_WORDS];

  // Results that have been predicted but not yet seen on the result port.
  retire_t pending_retires[$];
  drill_row_t drill[$];

  // Shared between the request and result sides: the chance, in percent, of
  // starting an idle burst in a given cycle, and the request for a long hold.
  int idle_pct = 0;
  bit hold_req = 1'b0;

  int mismatches = 0;
  int requests = 0;
  int retired = 0;
  int loads = 0;
  int stores = 0;
  int error_status = 0;

  function automatic logic [31:0] r_word(input logic [5:0] fn,
                                         input logic [4:0] rs, rt, rd, sh);
    return {OP_RTYPE, rs, rt, rd, sh, fn};
  endfunction

  function automatic logic [31:0] i_word(input logic [5:0] op, input logic [4:0] rs, rt,
                                         input logic [15:0] imm);
    return {op, rs, rt, imm};
  endfunction

  function automatic logic [31:0] j_word(input logic [5:0] op, input logic [25:0] target);
    return {op, target};
  endfunction

  // Executes one instruction against the architectural state and returns what
  // the block must report for it. Register, PC and memory updates happen here.
  function automatic retire_t execute_instr(input logic [31:0] w);
    logic [5:0] op;
    logic [5:0] fn;
    logic [4:0] rs;
    logic [4:0] rt;
    logic [4:0] rd;
    logic [4:0] sh;
    logic [15:0] imm;
    logic [31:0] simm;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] pc4;
    logic [31:0] jt;
    logic [MEM_AW-1:0] wa;
    retire_t r;
    op = w[31:26];
    rs = w[25:21];
    rt = w[20:16];
    rd = w[15:11];
    sh = w[10:6];
    fn = w[5:0];
    imm = w[15:0];
    simm = {{16{imm[15]}}, imm};
    a = (rs == 5'd0) ? '0 : arch_gpr[rs];
    b = (rt == 5'd0) ? '0 : arch_gpr[rt];
    pc4 = arch_pc + 32'd4;
    jt = (pc4 & JUMP_REGION_MASK) | {4'b0, w[25:0], 2'b00};
    wa = '0;
    r = '0;
    r.st = ST_OK;
    r.npc = pc4;
    case (op)
      OP_RTYPE: begin
        case (fn)
          FN_ADD: begin
            r.we = 1'b1; r.idx = rd; r.val = a + b;
          end
          FN_SUB: begin
            r.we = 1'b1; r.idx = rd; r.val = a - b;
          end
          FN_JR: r.npc = a;
          FN_SLT: begin
            r.we = 1'b1; r.idx = rd; r.val = {31'd0, $signed(a) < $signed(b)};
          end
          FN_SLL: begin
            r.we = 1'b1; r.idx = rd; r.val = b << sh;
          end
          FN_SRL: begin
            // A shift by zero leaves the destination alone.
            if (sh != 5'd0) begin
              r.we = 1'b1; r.idx = rd; r.val = b >> sh;
            end
          end
          default: r.st = ST_BAD_FUNCT;
        endcase
      end
      OP_J: r.npc = jt;
      OP_JAL: begin
        r.we = 1'b1; r.idx = 5'd31; r.val = pc4;
        r.npc = jt;
      end
      OP_BEQ: if (a == b) r.npc = pc4 + (simm << 2);
      OP_BNE: if (a != b) r.npc = pc4 + (simm << 2);
      OP_ADDI: begin
        r.we = 1'b1; r.idx = rt; r.val = a + simm;
      end
      OP_SLTI: begin
        r.we = 1'b1; r.idx = rt; r.val = {31'd0, $signed(a) < $signed(simm)};
      end
      OP_ORI: begin
        r.we = 1'b1; r.idx = rt; r.val = a | {16'd0, imm};
      end
      OP_LUI: begin
        r.we = 1'b1; r.idx = rt; r.val = {imm, 16'd0};
      end
      OP_LW: begin
        // The memory is a power of two deep, so wrapping is truncation.
        wa = MEM_AW'(a + simm);
        r.maddr = MEM_ADDR_W'(wa);
        r.we = 1'b1; r.idx = rt; r.val = arch_mem[wa];
      end
      OP_SW: begin
        wa = MEM_AW'(a + simm);
        r.maddr = MEM_ADDR_W'(wa);
        r.mwe = 1'b1; r.mval = b;
        arch_mem[wa] = b;
      end
      OP_COP1, OP_LWC1, OP_SWC1, OP_IO_A, OP_IO_B, OP_IO_C, OP_IO_D: r.st = ST_UNSUPPORTED;
      default: begin
        r.st = ST_INVALID;
        r.npc = arch_pc;
      end
    endcase
    // Register zero swallows writes, and a dropped write reports all zeros.
    if (r.we && r.idx == 5'd0) r.we = 1'b0;
    if (r.we) begin
      arch_gpr[r.idx] = r.val;
    end else begin
      r.idx = '0;
      r.val = '0;
    end
    arch_pc = r.npc;
    return r;
  endfunction

  // Draws one random instruction. Most are well-formed operations with random
  // operands; just over half of the memory traffic is steered into a small
  // window around word zero so that loads find earlier stores. The rest is
  // unknown function codes, unsupported opcodes and fully random words.
  function automatic logic [31:0] rand_instr();
    logic [5:0] r_fns [6];
    logic [5:0] alu_ops [4];
    logic [5:0] odd_ops [7];
    logic [31:0] noise;
    logic [15:0] near;
    int pick;
    r_fns = '{FN_ADD, FN_SUB, FN_SLT, FN_SLL, FN_SRL, FN_JR};
    alu_ops = '{OP_ADDI, OP_SLTI, OP_ORI, OP_LUI};
    odd_ops = '{OP_COP1, OP_LWC1, OP_SWC1, OP_IO_A, OP_IO_B, OP_IO_C, OP_IO_D};
    noise = $urandom;
    near = noise[15] ? {13'h1FFF, noise[2:0]} : {13'd0, noise[2:0]};
    pick = $urandom_range(0, 99);
    if (pick < 28) return {OP_RTYPE, noise[25:6], r_fns[$urandom_range(0, 5)]};
    if (pick < 48) return {alu_ops[$urandom_range(0, 3)], noise[25:0]};
    if (pick < 58) begin
      // Compare a register with itself now and then so branches get taken.
      if (noise[31]) return i_word(OP_BEQ, noise[25:21], noise[30] ? noise[25:21] : noise[20:16],
                                   noise[15:0]);
      return i_word(OP_BNE, noise[25:21], noise[30] ? noise[25:21] : noise[20:16], noise[15:0]);
    end
    if (pick < 63) return j_word(noise[31] ? OP_JAL : OP_J, noise[25:0]);
    if (pick < 75) return i_word(noise[31] ? OP_LW : OP_SW, 5'd0, noise[20:16], near);
    if (pick < 85) return {noise[31] ? OP_LW : OP_SW, noise[25:0]};
    if (pick < 90) return {OP_RTYPE, noise[25:0]};
    if (pick < 95) return {odd_ops[$urandom_range(0, 6)], noise[25:0]};
    return noise;
  endfunction

  // Appends one line to the directed drill.
  task automatic add_row(input logic [31:0] w, input logic known, input retire_t want);
    drill_row_t row;
    row.w = w;
    row.known = known;
    row.want = want;
    drill.insert(drill.size(), row);
  endtask

  // Offers one request and holds it until the block takes it. The caller is
  // at a rising edge; on return the request has just been accepted and valid
  // is still high, so the next call can present its word without a gap.
  task automatic issue(input logic [31:0] w, input logic known, input retire_t want);
    retire_t got;
    instr <= w;
    instr_valid <= 1'b1;
    @(posedge clk);
    while (instr_stall) @(posedge clk);
    got = execute_instr(w);
    pending_retires.insert(pending_retires.size(), known ? want : got);
    requests++;
    if (w[31:26] == OP_LW) loads++;
    if (got.mwe) stores++;
    if (got.st != ST_OK) error_status++;
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] seen);
    if (seen !== want) begin
      $error("%s: expected %h, got %h", name, want, seen);
      mismatches++;
    end
  endtask

  // Result side: every accepted result is matched against the oldest
  // prediction. Both valid and stall are read as they stood before the edge.
  always @(posedge clk) begin : result_check
    retire_t exp;
    if (result_valid === 1'b1 && result_stall === 1'b0) begin
      retired++;
      if (pending_retires.size() == 0) begin
        $error("result with no request outstanding: next_pc %h", next_pc);
        mismatches++;
      end else begin
        exp = pending_retires.pop_front();
        check_field("next_pc", exp.npc, next_pc);
        check_field("reg_we", 32'(exp.we), 32'(reg_we));
        check_field("reg_idx", 32'(exp.idx), 32'(reg_idx));
        check_field("reg_val", exp.val, reg_val);
        check_field("mem_we", 32'(exp.mwe), 32'(mem_we));
        check_field("mem_addr", 32'(exp.maddr), 32'(mem_addr));
        check_field("mem_val", exp.mval, mem_val);
        check_field("status", 32'(exp.st), 32'(status));
      end
    end
  end

  // Receiver. It stalls the result port in random bursts while idle_pct is
  // non-zero, and once, on request, holds off for a long stretch so that the
  // block fills up behind the held result and stalls its request channel.
  initial begin : result_side
    int burst;
    result_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        result_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        result_stall <= 1'b0;
        hold_req = 1'b0;
      end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
        burst = $urandom_range(1, 11);
        result_stall <= 1'b1;
        repeat (burst) @(posedge clk);
        result_stall <= 1'b0;
      end
    end
  end

  // Sender and run control.
  initial begin : stimulus
    retire_t blank;
    int n;
    blank = '0;
    rst = 1'b1;
    instr = '0;
    instr_valid = 1'b0;
    foreach (arch_gpr[i]) arch_gpr[i] = '0;
    foreach (arch_mem[i]) arch_mem[i] = '0;
    arch_pc = '0;

    // The first rows start from the reset state, so their results can be
    // written down directly: sign and zero extension of the immediate, a
    // write aimed at register zero, and the three error statuses.
    add_row(i_word(OP_LUI, 5'd0, 5'd1, 16'hFFFF), 1'b1,
            '{32'd4, 1'b1, 5'd1, 32'hFFFF_0000, 1'b0, 12'd0, 32'd0, ST_OK});
    add_row(i_word(OP_ORI, 5'd0, 5'd2, 16'hFFFF), 1'b1,
            '{32'd8, 1'b1, 5'd2, 32'h0000_FFFF, 1'b0, 12'd0, 32'd0, ST_OK});
    add_row(i_word(OP_ADDI, 5'd0, 5'd3, 16'h8000), 1'b1,
            '{32'd12, 1'b1, 5'd3, 32'hFFFF_8000, 1'b0, 12'd0, 32'd0, ST_OK});
    add_row(i_word(OP_ADDI, 5'd1, 5'd0, 16'h0001), 1'b1,
            '{32'd16, 1'b0, 5'd0, 32'd0, 1'b0, 12'd0, 32'd0, ST_OK});
    // An opcode outside every group holds the PC where it is.
    add_row(j_word(6'd1, 26'h3FF_FFFF), 1'b1,
            '{32'd16, 1'b0, 5'd0, 32'd0, 1'b0, 12'd0, 32'd0, ST_INVALID});
    add_row(j_word(OP_COP1, 26'h3FF_FFFF), 1'b1,
            '{32'd20, 1'b0, 5'd0, 32'd0, 1'b0, 12'd0, 32'd0, ST_UNSUPPORTED});
    add_row(r_word(6'd1, 5'd1, 5'd2, 5'd3, 5'd0), 1'b1,
            '{32'd24, 1'b0, 5'd0, 32'd0, 1'b0, 12'd0, 32'd0, ST_BAD_FUNCT});
    // From here on the model tracks the operands.
    add_row(r_word(FN_ADD, 5'd1, 5'd2, 5'd4, 5'd0), 1'b0, blank);
    add_row(r_word(FN_SUB, 5'd0, 5'd1, 5'd5, 5'd0), 1'b0, blank);
    add_row(r_word(FN_SLT, 5'd1, 5'd2, 5'd6, 5'd0), 1'b0, blank);
    add_row(i_word(OP_SLTI, 5'd2, 5'd7, 16'hFFFF), 1'b0, blank);
    add_row(r_word(FN_SLL, 5'd0, 5'd2, 5'd8, 5'd31), 1'b0, blank);
    add_row(r_word(FN_SRL, 5'd0, 5'd1, 5'd9, 5'd31), 1'b0, blank);
    // A logical right shift by zero must not touch its destination.
    add_row(r_word(FN_SRL, 5'd0, 5'd1, 5'd10, 5'd0), 1'b0, blank);
    add_row(32'h0000_0000, 1'b0, blank);
    // Store to word -1, which wraps to the top of memory, then read it back,
    // and read a word that was only ever cleared.
    add_row(i_word(OP_SW, 5'd0, 5'd2, 16'hFFFF), 1'b0, blank);
    add_row(i_word(OP_LW, 5'd0, 5'd11, 16'hFFFF), 1'b0, blank);
    add_row(i_word(OP_LW, 5'd0, 5'd12, 16'h0005), 1'b0, blank);
    add_row(i_word(OP_BEQ, 5'd0, 5'd0, 16'h0002), 1'b0, blank);
    add_row(i_word(OP_BNE, 5'd0, 5'd0, 16'h7FFF), 1'b0, blank);
    add_row(i_word(OP_BNE, 5'd1, 5'd2, 16'hFFFF), 1'b0, blank);
    add_row(j_word(OP_JAL, 26'h3FF_FFFF), 1'b0, blank);
    add_row(r_word(FN_JR, 5'd31, 5'd0, 5'd0, 5'd0), 1'b0, blank);
    add_row(32'hFFFF_FFFF, 1'b0, blank);
    add_row(j_word(OP_J, 26'h000_0000), 1'b0, blank);

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // The block sweeps its data memory after reset with the request channel
    // stalled; issue simply waits that out. The drill runs with the result
    // side stalling now and then and the request side back to back.
    idle_pct = 20;
    foreach (drill[i]) issue(drill[i].w, drill[i].known, drill[i].want);

    for (n = 0; n < RANDOM_ITEMS; n++) begin
      // Alternate busy and quiet phases; the final stretch runs flat out.
      if (n < 250) idle_pct = 25;
      else if (n < 500) idle_pct = 0;
      else if (n < 850) idle_pct = 40;
      else idle_pct = 0;

      if (n == 300) hold_req = 1'b1;

      if (n == 600) begin
        // Let the block run dry before the next request.
        instr_valid <= 1'b0;
        @(posedge clk);
        while (pending_retires.size() != 0) @(posedge clk);
      end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
        instr_valid <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
      end
      issue(rand_instr(), 1'b0, blank);
    end

    instr_valid <= 1'b0;
    while (pending_retires.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (pending_retires.size() != 0) begin
      $error("%0d results never arrived", pending_retires.size());
      mismatches++;
    end
    $display("Executed %0d requests (%0d directed), %0d results checked.",
             requests, drill.size(), retired);
    $display("Mix: %0d loads, %0d stores, %0d error statuses, %0d mismatches.",
             loads, stores, error_status, mismatches);
    if (mismatches == 0) begin
      $display("tb_integer_risc_instruction_step: PASS");
    end else begin
      $display("tb_integer_risc_instruction_step: FAIL");
    end
    $finish;
  end

  // Watchdog: far beyond the memory sweep plus the slowest legal run.
  initial begin : watchdog
    #2_000_000;
    $display("Timed out with %0d results outstanding.", pending_retires.size());
    $display("tb_integer_risc_instruction_step: FAIL");
    $finish;
  end

endmodule

// File: files.f
rtl/irs_pkg.sv
rtl/irs_regfile.sv
rtl/irs_exec.sv
rtl/irs_dmem.sv
rtl/integer_risc_instruction_step.sv
rtl/irs_checker.sv
sim/tb_integer_risc_instruction_step.sv
